FILE: hdl/pckp_pkg.sv
// shared types, constants and codes of the plasma colour-keyed pixel core
package pckp_pkg;

  localparam int unsigned TABLE_DEPTH = 512;
  localparam int unsigned TABLE_WIDTH = 16;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned SUM_W       = (TABLE_WIDTH + 2 > 12) ? TABLE_WIDTH + 2 : 12;
  localparam int unsigned ADDR_SUM_W  = 13;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned PHASE_W     = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_RED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_GREEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BLUE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_START = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_FIXED  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_FIXED = 3'd6;

  localparam logic [PHASE_W-1:0] VERT_STEP  = 9'd9;
  localparam logic [PHASE_W-1:0] HORIZ_STEP = 9'd8;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_FRAME = 2'd2
  } req_e;

  typedef logic signed [TABLE_WIDTH-1:0] word_t;
  typedef logic [ADDR_W-1:0]             addr_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

FILE: hdl/plasma_color_keyed_pixel_core.sv
// top level of the plasma colour-keyed pixel core
// a pixel transfer in passes the table read registers, then the output register
// throughput: one item per cycle unless the output stalls; the four table reads use two
// dual-read copies of the table; table writes and end-of-frame items give no result
// reset: asynchronous, active low; clears config, phases and valid flags, not the table
module plasma_color_keyed_pixel_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pckp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pckp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         req_type_i,
  input  logic [8:0]                         table_index_i,
  input  logic signed [15:0]                 table_value_i,
  input  logic [9:0]                         column_i,
  input  logic [9:0]                         row_i,
  input  logic [7:0]                         pixel_red_i,
  input  logic [7:0]                         pixel_green_i,
  input  logic [7:0]                         pixel_blue_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [7:0]                         out_red_o,
  output logic [7:0]                         out_green_o,
  output logic [7:0]                         out_blue_o,
  output logic                               replaced_o
);

  localparam int unsigned AW  = pckp_pkg::ADDR_SUM_W;
  localparam int unsigned PHW = pckp_pkg::PHASE_W;

  pckp_pkg::rgb_t   key_q;
  logic [PHW-1:0]   vert_off_q;
  logic [PHW-1:0]   horiz_off_q;
  logic [PHW-1:0]   vert_fixed_q;
  logic [PHW-1:0]   horiz_fixed_q;

  logic             acc;
  logic             acc_write;
  logic             acc_pixel;
  logic             acc_frame;
  logic             s1_adv;

  logic             s1_valid_q;
  pckp_pkg::rgb_t   s1_pixel_q;

  logic             out_valid_q;
  pckp_pkg::rgb_t   out_colour_q;
  logic             out_replaced_q;

  logic [AW-1:0]    sum_a0;
  logic [AW-1:0]    sum_a1;
  logic [AW-1:0]    sum_a2;
  logic [AW-1:0]    sum_a3;
  logic             tbl_we;
  pckp_pkg::addr_t  tbl_waddr;
  pckp_pkg::word_t  tbl_wdata;
  pckp_pkg::word_t  word0;
  pckp_pkg::word_t  word1;
  pckp_pkg::word_t  word2;
  pckp_pkg::word_t  word3;
  pckp_pkg::rgb_t   in_pixel;
  pckp_pkg::rgb_t   shade_colour;
  logic             shade_replaced;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign acc        = in_valid_i && in_ready_o;
  assign acc_write  = acc && (req_type_i == pckp_pkg::REQ_WRITE);
  assign acc_pixel  = acc && (req_type_i == pckp_pkg::REQ_PIXEL);
  assign acc_frame  = acc && (req_type_i == pckp_pkg::REQ_FRAME);

  assign in_pixel.red   = pixel_red_i;
  assign in_pixel.green = pixel_green_i;
  assign in_pixel.blue  = pixel_blue_i;

  // configuration and frame phases
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q         <= '0;
      vert_off_q    <= '0;
      horiz_off_q   <= '0;
      vert_fixed_q  <= '0;
      horiz_fixed_q <= '0;
    end else begin
      if (acc_frame) begin
        vert_off_q  <= vert_off_q + pckp_pkg::VERT_STEP;
        horiz_off_q <= horiz_off_q + pckp_pkg::HORIZ_STEP;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pckp_pkg::CFG_KEY_RED:     key_q.red     <= cfg_data_i[7:0];
          pckp_pkg::CFG_KEY_GREEN:   key_q.green   <= cfg_data_i[7:0];
          pckp_pkg::CFG_KEY_BLUE:    key_q.blue    <= cfg_data_i[7:0];
          pckp_pkg::CFG_VERT_START:  vert_off_q    <= cfg_data_i[PHW-1:0];
          pckp_pkg::CFG_HORIZ_START: horiz_off_q   <= cfg_data_i[PHW-1:0];
          pckp_pkg::CFG_VERT_FIXED:  vert_fixed_q  <= cfg_data_i[PHW-1:0];
          pckp_pkg::CFG_HORIZ_FIXED: horiz_fixed_q <= cfg_data_i[PHW-1:0];
          default: ;
        endcase
      end
    end
  end

  // table addressing
  always_comb begin
    sum_a0 = AW'(vert_off_q) + AW'(column_i) * AW'(5);
    sum_a1 = AW'(vert_fixed_q) + AW'(column_i) * AW'(3);
    sum_a2 = AW'(horiz_off_q) + AW'(row_i) * AW'(3);
    sum_a3 = AW'(horiz_fixed_q) + AW'(row_i);
  end

  assign tbl_we    = acc_write && (32'(table_index_i) < pckp_pkg::TABLE_DEPTH);
  assign tbl_waddr = pckp_pkg::ADDR_W'(table_index_i);
  assign tbl_wdata = pckp_pkg::TABLE_WIDTH'(table_value_i);

  pckp_wave_bank u_bank_col (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .waddr_i   (tbl_waddr),
    .wdata_i   (tbl_wdata),
    .re_i      (acc_pixel),
    .raddr_a_i (sum_a0[pckp_pkg::ADDR_W-1:0]),
    .raddr_b_i (sum_a1[pckp_pkg::ADDR_W-1:0]),
    .rdata_a_o (word0),
    .rdata_b_o (word1)
  );

  pckp_wave_bank u_bank_row (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .waddr_i   (tbl_waddr),
    .wdata_i   (tbl_wdata),
    .re_i      (acc_pixel),
    .raddr_a_i (sum_a2[pckp_pkg::ADDR_W-1:0]),
    .raddr_b_i (sum_a3[pckp_pkg::ADDR_W-1:0]),
    .rdata_a_o (word2),
    .rdata_b_o (word3)
  );

  // read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc_pixel) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_pixel) begin
      s1_pixel_q <= in_pixel;
    end
  end

  pckp_shade u_shade (
    .word0_i    (word0),
    .word1_i    (word1),
    .word2_i    (word2),
    .word3_i    (word3),
    .key_i      (key_q),
    .pixel_i    (s1_pixel_q),
    .colour_o   (shade_colour),
    .replaced_o (shade_replaced)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_colour_q   <= shade_colour;
      out_replaced_q <= shade_replaced;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_colour_q.red;
  assign out_green_o = out_colour_q.green;
  assign out_blue_o  = out_colour_q.blue;
  assign replaced_o  = out_replaced_q;

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_pixel_q)))
    else $error("read stage lost its item while stalled");

  a_pixel_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_pixel |=> s1_valid_q)
    else $error("pixel transfer did not reach the read stage");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with an empty read stage");

  a_frame_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_frame && !(cfg_we_i && (cfg_idx_i == pckp_pkg::CFG_VERT_START)))
      |=> (vert_off_q == $past(vert_off_q + pckp_pkg::VERT_STEP)))
    else $error("column phase did not advance at end of frame");

  a_blue_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && replaced_o) |-> (out_blue_o == 8'd0))
    else $error("replaced pixel carries blue");

endmodule

FILE: hdl/pckp_wave_bank.sv
// wave table copy with one write port and two registered read ports
module pckp_wave_bank (
  input  logic            clk_i,
  input  logic            we_i,
  input  pckp_pkg::addr_t waddr_i,
  input  pckp_pkg::word_t wdata_i,
  input  logic            re_i,
  input  pckp_pkg::addr_t raddr_a_i,
  input  pckp_pkg::addr_t raddr_b_i,
  output pckp_pkg::word_t rdata_a_o,
  output pckp_pkg::word_t rdata_b_o
);

  pckp_pkg::word_t mem [pckp_pkg::TABLE_DEPTH];
  pckp_pkg::word_t rd_a_q;
  pckp_pkg::word_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_a_q <= mem[raddr_a_i];
      rd_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

FILE: hdl/pckp_shade.sv
// wave sum, palette lookup and colour-key replacement
module pckp_shade (
  input  pckp_pkg::word_t word0_i,
  input  pckp_pkg::word_t word1_i,
  input  pckp_pkg::word_t word2_i,
  input  pckp_pkg::word_t word3_i,
  input  pckp_pkg::rgb_t  key_i,
  input  pckp_pkg::rgb_t  pixel_i,
  output pckp_pkg::rgb_t  colour_o,
  output logic            replaced_o
);

  logic signed [pckp_pkg::SUM_W-1:0] sum;
  logic [7:0]                        pal_idx;
  logic [7:0]                        quad;
  logic [7:0]                        pal_red;
  logic [7:0]                        pal_green;

  always_comb begin
    sum = pckp_pkg::SUM_W'(word0_i) + pckp_pkg::SUM_W'(word1_i)
        + pckp_pkg::SUM_W'(word2_i) + pckp_pkg::SUM_W'(word3_i);
    pal_idx = sum[11:4] + 8'd128;
    quad    = {pal_idx[5:0], 2'b00};
    case (pal_idx[7:6])
      2'd0: begin
        pal_red   = 8'd254 - quad;
        pal_green = quad;
      end
      2'd1: begin
        pal_red   = quad + 8'd1;
        pal_green = 8'd255;
      end
      2'd2: begin
        pal_red   = 8'd254 - quad;
        pal_green = 8'd254 - quad;
      end
      default: begin
        pal_red   = quad + 8'd1;
        pal_green = 8'd0;
      end
    endcase
  end

  always_comb begin
    replaced_o = (pixel_i == key_i);
    if (replaced_o) begin
      colour_o.red   = pal_red;
      colour_o.green = pal_green;
      colour_o.blue  = 8'd0;
    end else begin
      colour_o = pixel_i;
    end
  end

endmodule
